@@ hdl/deq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  localparam int OpW      = 3;
  localparam int PosW     = 6;
  localparam int ValW     = 32;
  localparam int StatW    = 2;
  localparam int CntOutW  = 7;

  localparam int DataWidthDef = 32;
  localparam int DepthDef     = 64;

  typedef enum logic [OpW-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_READ       = 3'd4,
    OP_WRITE      = 3'd5
  } op_t;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic [ValW-1:0]    value;
    status_t            status;
    logic [CntOutW-1:0] count;
  } res_t;

endpackage

`default_nettype wire

@@ hdl/deq_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface deq_in_if;
  logic                      valid;
  logic                      ready;
  logic [deq_pkg::OpW-1:0]   opcode;
  logic [deq_pkg::PosW-1:0]  position;
  logic [deq_pkg::ValW-1:0]  item_value;

  modport source (output valid, output opcode, output position, output item_value,
                  input ready);
  modport sink (input valid, input opcode, input position, input item_value,
                output ready);
endinterface

interface deq_out_if;
  logic                         valid;
  logic                         ready;
  logic [deq_pkg::ValW-1:0]     result_value;
  logic [deq_pkg::StatW-1:0]    status;
  logic [deq_pkg::CntOutW-1:0]  count;

  modport source (output valid, output result_value, output status, output count,
                  input ready);
  modport sink (input valid, input result_value, input status, input count,
                output ready);
endinterface

`default_nettype wire

@@ hdl/double_ended_queue_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Double-ended queue of up to DEPTH words on a ring buffer.
// in_chan carries one operation per word: push front or back, pop front or
// back, read or overwrite the word at a position counted from the front.
// out_chan returns exactly one result per operation, in order: the popped or
// read word (zero otherwise), a status (ok, empty, full, out of range) and the
// number of stored words after the operation.
// An operation is decoded and its storage access done at the edge that accepts
// it; its result is registered in the stage in front of the output queue and
// then written into that queue. One operation is accepted every cycle while
// in_ready is high, set by the single storage port that each operation uses.
// Results wait in a four-entry output queue; when the receiver stalls, in_ready
// falls once that queue and the stage in front of it hold four results between
// them, and rises again as results are taken.
// Reset empties the queue and drops any results not yet taken. Storage words
// are not cleared; only words written by a push or an overwrite are ever read back.
module double_ended_queue_unit #(
  parameter int DATA_WIDTH = deq_pkg::DataWidthDef,
  parameter int DEPTH      = deq_pkg::DepthDef
) (
  input  wire logic clk,
  input  wire logic rst_n,
  deq_in_if.sink    in_chan,
  deq_out_if.source out_chan
);
  import deq_pkg::*;

  localparam int StoreW  = (DATA_WIDTH < ValW) ? DATA_WIDTH : ValW;
  localparam int PtrW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW    = $clog2(DEPTH + 1);
  localparam int MaxW    = (CntW > PosW) ? CntW : PosW;
  localparam int SumW    = MaxW + 1;
  localparam int BufD    = 4;
  localparam int BufPtrW = 2;
  localparam int BufCntW = 3;

  // (a + b) mod DEPTH; both operands are below DEPTH wherever the result is used.
  function automatic logic [PtrW-1:0] ring_add(input logic [SumW-1:0] a,
                                               input logic [SumW-1:0] b);
    logic [SumW-1:0] s;
    s = a + b;
    if (s >= SumW'(DEPTH)) begin
      s = s - SumW'(DEPTH);
    end
    return s[PtrW-1:0];
  endfunction

  logic [StoreW-1:0] slots [DEPTH];
  logic [StoreW-1:0] rdata_r;

  logic [PtrW-1:0] front_r, front_nxt;
  logic [CntW-1:0] fill_r, fill_nxt;

  logic            in_fire;
  op_t             op;
  status_t         st;
  logic            wr_en;
  logic            rd_en;
  logic [PtrW-1:0] addr;
  logic [SumW-1:0] front_ext;
  logic [SumW-1:0] fill_ext;
  logic [SumW-1:0] pos_ext;
  logic            full;
  logic            empty;
  logic            pos_ok;

  logic               s1_valid_r;
  logic               s1_rd_r;
  status_t            s1_status_r;
  logic [CntOutW-1:0] s1_count_r;

  res_t               buf_r [BufD];
  logic [BufPtrW-1:0] buf_wp_r;
  logic [BufPtrW-1:0] buf_rp_r;
  logic [BufCntW-1:0] buf_cnt_r;
  logic               out_fire;
  res_t               s1_res;
  res_t               head;

  assign in_fire   = in_chan.valid && in_chan.ready;
  assign op        = op_t'(in_chan.opcode);
  assign front_ext = SumW'(front_r);
  assign fill_ext  = SumW'(fill_r);
  assign pos_ext   = SumW'(in_chan.position);
  assign full      = (fill_r == CntW'(DEPTH));
  assign empty     = (fill_r == '0);
  assign pos_ok    = (pos_ext < fill_ext);

  always_comb begin
    front_nxt = front_r;
    fill_nxt  = fill_r;
    st        = ST_OK;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    addr      = '0;
    unique case (op)
      OP_PUSH_FRONT: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          front_nxt = (front_r == '0) ? PtrW'(DEPTH - 1) : front_r - 1'b1;
          addr      = front_nxt;
          wr_en     = 1'b1;
          fill_nxt  = fill_r + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          addr     = ring_add(front_ext, fill_ext);
          wr_en    = 1'b1;
          fill_nxt = fill_r + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          addr      = front_r;
          rd_en     = 1'b1;
          front_nxt = ring_add(front_ext, SumW'(1));
          fill_nxt  = fill_r - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          fill_nxt = fill_r - 1'b1;
          addr     = ring_add(front_ext, SumW'(fill_nxt));
          rd_en    = 1'b1;
        end
      end
      OP_READ: begin
        if (!pos_ok) begin
          st = ST_RANGE;
        end else begin
          addr  = ring_add(front_ext, pos_ext);
          rd_en = 1'b1;
        end
      end
      OP_WRITE: begin
        if (!pos_ok) begin
          st = ST_RANGE;
        end else begin
          addr  = ring_add(front_ext, pos_ext);
          wr_en = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // A write lands at the accepting edge, so the next operation already reads it.
  always_ff @(posedge clk) begin
    if (in_fire && wr_en) begin
      slots[addr] <= in_chan.item_value[StoreW-1:0];
    end
    if (in_fire && rd_en) begin
      rdata_r <= slots[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r    <= '0;
      fill_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
      if (in_fire) begin
        front_r <= front_nxt;
        fill_r  <= fill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_rd_r     <= rd_en;
      s1_status_r <= st;
      s1_count_r  <= CntOutW'(fill_nxt);
    end
  end

  assign s1_res.value  = s1_rd_r ? ValW'(rdata_r) : '0;
  assign s1_res.status = s1_status_r;
  assign s1_res.count  = s1_count_r;

  // The stage in front always drains into the output queue; acceptance is
  // held back so that the queue always has room for it.
  assign out_fire      = out_chan.valid && out_chan.ready;
  assign in_chan.ready = (buf_cnt_r + BufCntW'(s1_valid_r)) != BufCntW'(BufD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_wp_r  <= '0;
      buf_rp_r  <= '0;
      buf_cnt_r <= '0;
    end else begin
      if (s1_valid_r) begin
        buf_wp_r <= buf_wp_r + 1'b1;
      end
      if (out_fire) begin
        buf_rp_r <= buf_rp_r + 1'b1;
      end
      buf_cnt_r <= buf_cnt_r + BufCntW'(s1_valid_r) - BufCntW'(out_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      buf_r[buf_wp_r] <= s1_res;
    end
  end

  assign head                  = buf_r[buf_rp_r];
  assign out_chan.valid        = (buf_cnt_r != '0);
  assign out_chan.result_value = head.value;
  assign out_chan.status       = head.status;
  assign out_chan.count        = head.count;

endmodule

`default_nettype wire

@@ tb/deq_scoreboard.sv @@
`timescale 1ns / 1ps

module deq_scoreboard (
  input  logic        clk,
  input  logic        rst_n,
  deq_in_if           op_mon,
  deq_out_if          res_mon,
  output int unsigned fail_count,
  output int unsigned outstanding
);
  import deq_pkg::*;

  localparam int Depth      = DepthDef;
  localparam int MaxReports = 10;

  logic [ValW-1:0]    ring [Depth];
  logic [PosW-1:0]    head;
  logic [CntOutW-1:0] fill;
  res_t               expected_q [$];
  res_t               want;
  int unsigned        failures = 0;

  assign fail_count  = failures;
  assign outstanding = expected_q.size();

  // Applies one operation to the shadow deque and returns the result it must give.
  // The ring indexes are PosW bits wide, so wrap-around is implicit.
  function automatic res_t apply_op(logic [OpW-1:0] op, logic [PosW-1:0] pos,
                                    logic [ValW-1:0] val);
    res_t            r;
    logic [PosW-1:0] slot;
    r.value  = '0;
    r.status = ST_OK;
    case (op)
      OP_PUSH_FRONT: begin
        if (fill == CntOutW'(Depth)) begin
          r.status = ST_FULL;
        end else begin
          head       = head - 1'b1;
          ring[head] = val;
          fill       = fill + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (fill == CntOutW'(Depth)) begin
          r.status = ST_FULL;
        end else begin
          slot       = head + fill[PosW-1:0];
          ring[slot] = val;
          fill       = fill + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (fill == '0) begin
          r.status = ST_EMPTY;
        end else begin
          r.value = ring[head];
          head    = head + 1'b1;
          fill    = fill - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (fill == '0) begin
          r.status = ST_EMPTY;
        end else begin
          fill    = fill - 1'b1;
          slot    = head + fill[PosW-1:0];
          r.value = ring[slot];
        end
      end
      OP_READ: begin
        if ({1'b0, pos} >= fill) begin
          r.status = ST_RANGE;
        end else begin
          slot    = head + pos;
          r.value = ring[slot];
        end
      end
      OP_WRITE: begin
        if ({1'b0, pos} >= fill) begin
          r.status = ST_RANGE;
        end else begin
          slot       = head + pos;
          ring[slot] = val;
        end
      end
      default: ;  // unused opcodes leave everything as it is
    endcase
    r.count = fill;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      head = '0;
      fill = '0;
      expected_q.delete();
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (expected_q.size() == 0) begin
          failures++;
          if (failures <= MaxReports)
            $display("%0t: result word with nothing expected: value %h status %0d count %0d",
                     $realtime, res_mon.result_value, res_mon.status, res_mon.count);
        end else begin
          want = expected_q.pop_front();
          if (res_mon.result_value !== want.value || res_mon.status !== want.status ||
              res_mon.count !== want.count) begin
            failures++;
            if (failures <= MaxReports) begin
              $display("%0t: mismatch: expected value %h status %0d count %0d",
                       $realtime, want.value, want.status, want.count);
              $display("%0t:           got value %h status %0d count %0d",
                       $realtime, res_mon.result_value, res_mon.status, res_mon.count);
            end
          end
        end
      end
      if (op_mon.valid && op_mon.ready)
        expected_q.push_back(apply_op(op_mon.opcode, op_mon.position, op_mon.item_value));
    end
  end

endmodule

@@ tb/tb_double_ended_queue_unit.sv @@
`timescale 1ns / 1ps

module tb_double_ended_queue_unit;
  import deq_pkg::*;

  // Opcodes the block must ignore while still answering.
  localparam logic [OpW-1:0] OpSpareLo = 3'd6;
  localparam logic [OpW-1:0] OpSpareHi = 3'd7;

  localparam int Depth        = DepthDef;
  localparam int SettleCycles = 16;
  localparam int DrainLimit   = 20000;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  bit          send_idle;
  bit          recv_idle;
  int unsigned stall_left;
  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned waited;

  deq_in_if  op_chan ();
  deq_out_if res_chan ();

  double_ended_queue_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (op_chan),
    .out_chan (res_chan)
  );

  deq_scoreboard u_scoreboard (
    .clk         (clk),
    .rst_n       (rst_n),
    .op_mon      (op_chan),
    .res_mon     (res_chan),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #4 clk = ~clk;

  // Receiver: takes result words, with random stall bursts while enabled.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      res_chan.ready = 1'b0;
      stall_left--;
    end else if (recv_idle && $urandom_range(0, 5) == 0) begin
      res_chan.ready = 1'b0;
      stall_left     = $urandom_range(0, 7);
    end else begin
      res_chan.ready = 1'b1;
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL double_ended_queue_unit");
    $finish;
  end

  function automatic logic [ValW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Half of the positions stay small so that reads and writes often land in range.
  function automatic logic [PosW-1:0] pick_pos();
    if ($urandom_range(0, 1) == 0) return PosW'($urandom_range(0, 7));
    return PosW'($urandom_range(0, Depth - 1));
  endfunction

  function automatic logic [OpW-1:0] pick_op();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 14) return OP_PUSH_FRONT;
    if (roll < 28) return OP_PUSH_BACK;
    if (roll < 42) return OP_POP_FRONT;
    if (roll < 56) return OP_POP_BACK;
    if (roll < 76) return OP_READ;
    if (roll < 94) return OP_WRITE;
    if (roll < 97) return OpSpareLo;
    return OpSpareHi;
  endfunction

  // Drives one word and returns at the falling edge after it was accepted.
  task automatic send_word(input logic [OpW-1:0] op, input logic [PosW-1:0] pos,
                           input logic [ValW-1:0] val);
    int unsigned gap;
    if (send_idle && $urandom_range(0, 4) == 0) begin
      gap           = $urandom_range(1, 8);
      op_chan.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    op_chan.valid      = 1'b1;
    op_chan.opcode     = op;
    op_chan.position   = pos;
    op_chan.item_value = val;
    do @(posedge clk); while (!op_chan.ready);
    @(negedge clk);
  endtask

  // Pushes past full, reads and overwrites the back end of a full queue, then pops past empty.
  task automatic fill_and_drain(input int unsigned extra);
    repeat (Depth + extra)
      send_word($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_pos(), pick_value());
    send_word(OP_READ, PosW'(Depth - 1), pick_value());
    send_word(OP_WRITE, PosW'(Depth - 1), pick_value());
    send_word(OP_READ, PosW'(Depth - 1), pick_value());
    repeat (8)
      send_word($urandom_range(0, 1) ? OP_READ : OP_WRITE, PosW'($urandom_range(0, Depth - 1)),
                pick_value());
    repeat (Depth + extra)
      send_word($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, pick_pos(), pick_value());
  endtask

  initial begin
    op_chan.valid      = 1'b0;
    op_chan.opcode     = OP_PUSH_FRONT;
    op_chan.position   = '0;
    op_chan.item_value = '0;
    res_chan.ready     = 1'b0;
    send_idle          = 1'b1;
    recv_idle          = 1'b1;
    stall_left         = 0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Empty queue, ignored opcodes, a small deque across the ring seam.
    send_word(OP_POP_FRONT, '0, '0);
    send_word(OP_POP_BACK, '1, '1);
    send_word(OP_READ, '0, '0);
    send_word(OP_WRITE, '1, '1);
    send_word(OpSpareLo, '1, '1);
    send_word(OpSpareHi, '0, '0);
    send_word(OP_PUSH_FRONT, '0, 32'hFFFF_FFFF);
    send_word(OP_PUSH_BACK, '0, 32'h0000_0000);
    send_word(OP_PUSH_FRONT, '0, 32'h8000_0001);
    send_word(OP_PUSH_BACK, '0, 32'h7FFF_FFFE);
    send_word(OP_READ, 6'd0, '0);
    send_word(OP_READ, 6'd3, '0);
    send_word(OP_READ, 6'd4, '0);
    send_word(OP_WRITE, 6'd2, 32'hA5A5_A5A5);
    send_word(OP_READ, 6'd2, '0);
    send_word(OP_READ, '1, '0);
    send_word(OP_POP_BACK, '0, '0);
    send_word(OP_POP_FRONT, '0, '0);
    send_word(OP_POP_FRONT, '0, '0);
    send_word(OP_POP_BACK, '0, '0);
    send_word(OP_POP_BACK, '0, '0);
    send_word(OP_PUSH_BACK, '0, 32'h0000_0001);
    send_word(OP_READ, 6'd0, '0);
    send_word(OP_POP_FRONT, '0, '0);

    for (int pass = 0; pass < 3; pass++) begin
      send_idle = (pass != 1);
      recv_idle = 1'($urandom_range(0, 1));
      fill_and_drain($urandom_range(2, 6));
    end

    send_idle = 1'b1;
    recv_idle = 1'b1;
    repeat (150) send_word(pick_op(), pick_pos(), pick_value());
    send_idle = 1'b0;
    repeat (60) send_word(pick_op(), pick_pos(), pick_value());
    send_idle = 1'b1;
    recv_idle = 1'b0;
    repeat (90) send_word(pick_op(), pick_pos(), pick_value());

    // Let the block run completely dry before the final stretch.
    op_chan.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);

    send_idle = 1'b0;
    recv_idle = 1'b0;
    repeat (150) send_word(pick_op(), pick_pos(), pick_value());
    op_chan.valid = 1'b0;

    waited = 0;
    while (outstanding != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    if (outstanding != 0) begin
      $display("FAIL double_ended_queue_unit");
      $finish;
    end else begin
      repeat (SettleCycles) @(posedge clk);
      if (fail_count == 0)
        $display("PASS double_ended_queue_unit");
      else
        $display("FAIL double_ended_queue_unit");
      $finish;
    end
  end

endmodule
